>>> rtl/core/rleg_pkg.sv
// Shared types and constants for the region-of-interest luma exposure gate.
`timescale 1ns / 1ps

package rleg_pkg;

  localparam int LUMA_W = 8;
  localparam int SUM_W = 27;
  localparam int CNT_W = 19;
  localparam int POS_W = 13;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int QUO_W = 8;
  localparam int STEP_W = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [LUMA_W-1:0] LUMA_MAX = 8'hFF;

  localparam logic [1:0] GATE_OK = 2'd0;
  localparam logic [1:0] GATE_DARK = 2'd1;
  localparam logic [1:0] GATE_BRIGHT = 2'd2;
  localparam logic [1:0] GATE_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_COLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_MEAN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_PEAK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MEAN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_FLOOR = 3'd7;

  localparam logic [9:0] RST_CROP_LEFT = 10'd0;
  localparam logic [8:0] RST_CROP_TOP = 9'd0;
  localparam logic [9:0] RST_CROP_COLS = 10'd640;
  localparam logic [8:0] RST_CROP_ROWS = 9'd480;
  localparam logic [7:0] RST_DARK_MEAN = 8'd40;
  localparam logic [7:0] RST_DARK_PEAK = 8'd96;
  localparam logic [7:0] RST_BRIGHT_MEAN = 8'd200;
  localparam logic [7:0] RST_BRIGHT_FLOOR = 8'd64;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [1:0]        gate_class;
    logic [LUMA_W-1:0] mean_luma;
    logic [LUMA_W-1:0] min_luma;
    logic [LUMA_W-1:0] max_luma;
    logic [CNT_W-1:0]  crop_samples;
  } result_t;

  typedef struct packed {
    logic [9:0] left;
    logic [8:0] top;
    logic [9:0] cols;
    logic [8:0] rows;
  } crop_cfg_t;

  typedef struct packed {
    logic [LUMA_W-1:0] dark_mean;
    logic [LUMA_W-1:0] dark_peak;
    logic [LUMA_W-1:0] bright_mean;
    logic [LUMA_W-1:0] bright_floor;
  } limits_t;

  // Per-frame statistics handed from the front end to the back end.
  typedef struct packed {
    logic              invalid;
    logic [SUM_W-1:0]  run_sum;
    logic [CNT_W-1:0]  run_count;
    logic [LUMA_W-1:0] run_min;
    logic [LUMA_W-1:0] run_max;
  } summary_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

>>> rtl/core/rleg_front.sv
// Front end: raster position tracking, crop statistics and frame checks.
`timescale 1ns / 1ps

module rleg_front import rleg_pkg::*; #(
  parameter int FRAME_WIDTH = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  pixel_t    pixel,
  input  crop_cfg_t crop,
  output logic      q_push,
  output summary_t  q_data
);

  localparam int COL_W = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W = $clog2(FRAME_HEIGHT + 1);
  localparam logic [POS_W-1:0] W_C = POS_W'(FRAME_WIDTH);
  localparam logic [POS_W-1:0] H_C = POS_W'(FRAME_HEIGHT);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [LUMA_W-1:0] run_min;
  logic [LUMA_W-1:0] run_max;
  logic [SUM_W-1:0]  run_sum;
  logic [CNT_W-1:0]  run_count;

  logic [LUMA_W-1:0] run_min_next;
  logic [LUMA_W-1:0] run_max_next;
  logic [SUM_W-1:0]  run_sum_next;
  logic [CNT_W-1:0]  run_count_next;

  logic [POS_W-1:0] col_x;
  logic [POS_W-1:0] row_x;
  logic [POS_W-1:0] x_end;
  logic [POS_W-1:0] y_end;
  logic             row_live;
  logic             col_last;
  logic             in_crop;
  logic             short_frame;
  logic             truncated;
  logic             invalid;

  assign col_x = POS_W'(col);
  assign row_x = POS_W'(row);
  assign x_end = POS_W'(crop.left) + POS_W'(crop.cols);
  assign y_end = POS_W'(crop.top) + POS_W'(crop.rows);
  assign row_live = row_x < H_C;
  assign col_last = col_x == (W_C - POS_W'(1));

  assign in_crop = row_live && (row_x >= POS_W'(crop.top)) && (row_x < y_end) &&
                   (col_x >= POS_W'(crop.left)) && (col_x < x_end);

  always_comb begin
    run_min_next = (in_crop && pixel.luma < run_min) ? pixel.luma : run_min;
    run_max_next = (in_crop && pixel.luma > run_max) ? pixel.luma : run_max;
    run_sum_next = run_sum + (in_crop ? SUM_W'(pixel.luma) : SUM_W'(0));
    run_count_next = run_count + CNT_W'(in_crop);
  end

  // The frame is too short when it ends inside the first line, and truncated when
  // its last pixel comes before the bottom-right pixel of the crop in raster order.
  assign short_frame = (row_x == POS_W'(0)) && (col_x < (W_C - POS_W'(1)));
  assign truncated = (row_x < (y_end - POS_W'(1))) ||
                     ((row_x == (y_end - POS_W'(1))) && (col_x < (x_end - POS_W'(1))));
  assign invalid = (x_end > W_C) || (y_end > H_C) || short_frame ||
                   (crop.rows == 9'd0) || (crop.cols == 10'd0) ||
                   (run_count_next == CNT_W'(0)) || truncated;

  assign q_push = accept && pixel.frame_end;

  always_comb begin
    q_data.invalid = invalid;
    q_data.run_sum = run_sum_next;
    q_data.run_count = run_count_next;
    q_data.run_min = run_min_next;
    q_data.run_max = run_max_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      run_min <= LUMA_MAX;
      run_max <= '0;
      run_sum <= '0;
      run_count <= '0;
    end else if (accept) begin
      if (pixel.frame_end) begin
        col <= '0;
        row <= '0;
        run_min <= LUMA_MAX;
        run_max <= '0;
        run_sum <= '0;
        run_count <= '0;
      end else begin
        run_min <= run_min_next;
        run_max <= run_max_next;
        run_sum <= run_sum_next;
        run_count <= run_count_next;
        // Past the last row the position parks at the start of a phantom row.
        if (row_live) begin
          if (col_last) begin
            col <= '0;
            row <= row + ROW_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/rleg_queue.sv
// Short queue of frame summaries between the front end and the back end.
`timescale 1ns / 1ps

module rleg_queue import rleg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  summary_t wr_data,
  input  logic     rd_en,
  output logic     full,
  output logic     valid,
  output summary_t rd_data
);

  summary_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_wr;
  logic                 do_rd;

  assign full = count == Q_CNT_W'(Q_DEPTH);
  assign valid = count != Q_CNT_W'(0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? Q_PTR_W'(0) : wr_ptr + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? Q_PTR_W'(0) : rd_ptr + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/rleg_back.sv
// Back end: serial mean division, exposure classification and result register.
`timescale 1ns / 1ps

module rleg_back import rleg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  summary_t q_data,
  output logic     q_pop,
  input  limits_t  limits,
  input  logic     pop,
  output logic     res_valid,
  output result_t  res
);

  back_state_t       state;
  back_state_t       state_next;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  rem_next;
  logic [SUM_W-1:0]  dsh;
  logic [SUM_W-1:0]  dsh_next;
  logic [QUO_W-1:0]  quo;
  logic [QUO_W-1:0]  quo_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  summary_t          cur;
  summary_t          cur_next;
  logic              res_valid_next;
  result_t           res_next;
  logic              load_res;
  result_t           built;

  // Classification of the finished frame from the quotient and its extremes.
  always_comb begin
    built.mean_luma = quo;
    built.min_luma = cur.run_min;
    built.max_luma = cur.run_max;
    built.crop_samples = cur.run_count;
    if (quo < limits.dark_mean && cur.run_max <= limits.dark_peak) begin
      built.gate_class = GATE_DARK;
    end else if (quo >= limits.bright_mean && cur.run_min >= limits.bright_floor) begin
      built.gate_class = GATE_BRIGHT;
    end else begin
      built.gate_class = GATE_OK;
    end
    if (cur.invalid) begin
      built = '0;
      built.gate_class = GATE_INVALID;
    end
  end

  always_comb begin
    state_next = state;
    rem_next = rem;
    dsh_next = dsh;
    quo_next = quo;
    step_next = step;
    cur_next = cur;
    q_pop = 1'b0;
    load_res = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cur_next = q_data;
          rem_next = q_data.run_sum;
          // The mean never exceeds the largest luma, so eight quotient bits suffice.
          dsh_next = SUM_W'({q_data.run_count, 7'b0});
          quo_next = '0;
          step_next = '0;
          state_next = q_data.invalid ? B_OUT : B_DIV;
        end
      end
      B_DIV: begin
        if (rem >= dsh) begin
          rem_next = rem - dsh;
          quo_next = {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo_next = {quo[QUO_W-2:0], 1'b0};
        end
        dsh_next = dsh >> 1;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(QUO_W - 1)) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!res_valid || pop) begin
          load_res = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
    if (load_res) begin
      res_valid_next = 1'b1;
      res_next = built;
    end else begin
      res_valid_next = res_valid && !pop;
      res_next = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      res_valid <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      res_valid <= res_valid_next;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    dsh <= dsh_next;
    quo <= quo_next;
    cur <= cur_next;
    res <= res_next;
  end

endmodule

>>> rtl/core/roi_luma_exposure_gate.sv
// Pixels are taken one per clock while full is low; full rises only while two frame summaries wait.
// A frame's summary waits in the queue from its frame-end beat until the back end is idle.
// The back end handles one summary at a time: a valid frame goes through the 8-step mean
// divider, an invalid one skips it, and either waits until the result register is free.
// Synchronous reset returns position, statistics, the queue and the configuration registers to defaults.
`timescale 1ns / 1ps

module roi_luma_exposure_gate import rleg_pkg::*; #(
  parameter int FRAME_WIDTH = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  pixel_t                pixel,
  input  logic                  pop,
  output logic                  empty,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  crop_cfg_t crop;
  limits_t   limits;
  logic      accept;
  logic      q_push;
  summary_t  q_wdata;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  summary_t  q_rdata;
  logic      res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop.left <= RST_CROP_LEFT;
      crop.top <= RST_CROP_TOP;
      crop.cols <= RST_CROP_COLS;
      crop.rows <= RST_CROP_ROWS;
      limits.dark_mean <= RST_DARK_MEAN;
      limits.dark_peak <= RST_DARK_PEAK;
      limits.bright_mean <= RST_BRIGHT_MEAN;
      limits.bright_floor <= RST_BRIGHT_FLOOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CROP_LEFT:    crop.left <= cfg_data[9:0];
        REG_CROP_TOP:     crop.top <= cfg_data[8:0];
        REG_CROP_COLS:    crop.cols <= cfg_data[9:0];
        REG_CROP_ROWS:    crop.rows <= cfg_data[8:0];
        REG_DARK_MEAN:    limits.dark_mean <= cfg_data[7:0];
        REG_DARK_PEAK:    limits.dark_peak <= cfg_data[7:0];
        REG_BRIGHT_MEAN:  limits.bright_mean <= cfg_data[7:0];
        REG_BRIGHT_FLOOR: limits.bright_floor <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign full = q_full;
  assign accept = push && !q_full;
  assign empty = !res_valid;

  rleg_front #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .pixel(pixel),
    .crop(crop),
    .q_push(q_push),
    .q_data(q_wdata)
  );

  rleg_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(q_push),
    .wr_data(q_wdata),
    .rd_en(q_pop),
    .full(q_full),
    .valid(q_valid),
    .rd_data(q_rdata)
  );

  rleg_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_rdata),
    .q_pop(q_pop),
    .limits(limits),
    .pop(pop),
    .res_valid(res_valid),
    .res(result)
  );

`ifndef SYNTHESIS
  // A frame-end beat is never taken while the summary queue has no room.
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("frame summary pushed into a full queue");

  // An invalid frame carries all-zero statistics.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.gate_class == GATE_INVALID) |->
      (result.crop_samples == '0 && result.mean_luma == '0 &&
       result.min_luma == '0 && result.max_luma == '0))
    else $error("invalid result with nonzero statistics");

  // A classified frame always measured at least one sample, within its extremes.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.gate_class != GATE_INVALID) |->
      (result.crop_samples != '0 && result.min_luma <= result.mean_luma &&
       result.mean_luma <= result.max_luma))
    else $error("classified result with inconsistent statistics");
`endif

endmodule
